// ===== design/mt64_pkg.sv =====
// ----------------------------------------------------------------------------
// mt64_pkg
// Shared types and constants for the 64-bit Mersenne Twister generator.
// ----------------------------------------------------------------------------
package mt64_pkg;

    // state store geometry
    localparam int unsigned C_STATE_WORDS  = 312;
    localparam int unsigned C_SHIFT_OFFSET = 156;
    localparam int unsigned C_IDX_W        = 9;
    localparam int unsigned C_POS_W        = 9;

    localparam logic [C_IDX_W-1:0] C_LAST_IDX  = C_IDX_W'(C_STATE_WORDS - 1);
    localparam logic [C_IDX_W-1:0] C_SHIFT_IDX = C_IDX_W'(C_SHIFT_OFFSET);
    localparam logic [C_POS_W-1:0] C_POS_TWIST = C_POS_W'(C_STATE_WORDS);
    localparam logic [C_POS_W-1:0] C_POS_UNSEEDED = C_POS_W'(C_STATE_WORDS + 1);

    // recurrence constants
    localparam logic [63:0] C_TWIST_MATRIX = 64'hB5026F5AA96619E9;
    localparam logic [63:0] C_UPPER_MASK   = 64'hFFFFFFFF80000000;
    localparam logic [63:0] C_LOWER_MASK   = 64'h000000007FFFFFFF;
    localparam logic [63:0] C_SEED_MULT    = 64'd6364136223846793005;
    localparam logic [63:0] C_DEFAULT_SEED = 64'd5489;

    // input action codes
    localparam logic C_ACT_DRAW   = 1'b0;
    localparam logic C_ACT_RESEED = 1'b1;

    // write data source for the state store
    typedef enum logic [1:0] {
        WSEL_SEED_IN,
        WSEL_SEED_CALC,
        WSEL_TWIST
    } t_wsel;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_SUM,
        ST_TW_PRIME,
        ST_TW_LOAD,
        ST_TW_READ,
        ST_TW_WRITE,
        ST_DRAW_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic               mem_we;
        logic [C_IDX_W-1:0] waddr;
        t_wsel              wsel;
        logic               rd_en;
        logic [C_IDX_W-1:0] addr_a;
        logic [C_IDX_W-1:0] addr_b;
        logic               seed_init;
        logic               seed_default;
        logic               mul_en;
        logic               sum_en;
        logic               cur_load;
        logic               out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ===== design/mt64_datapath.sv =====
// ----------------------------------------------------------------------------
// mt64_datapath
// State store, seeding multiplier, twist logic and tempered output register.
// ----------------------------------------------------------------------------
module mt64_datapath
    import mt64_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_dp_cmd      i_cmd,
    output t_dp_status   o_status,
    input  logic [63:0]  i_seed_value,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [63:0]  o_random_word
);

    // temper one state word
    function automatic logic [63:0] f_temper(input logic [63:0] x);
        logic [63:0] t;
        t = x;
        t = t ^ ((t >> 29) & 64'h5555555555555555);
        t = t ^ ((t << 17) & 64'h71D67FFFEDA60000);
        t = t ^ ((t << 37) & 64'hFFF7EEE000000000);
        t = t ^ (t >> 43);
        return t;
    endfunction

    logic [63:0] r_mem [C_STATE_WORDS];
    logic [63:0] r_rd_a;
    logic [63:0] r_rd_b;
    logic [63:0] r_cur;
    logic [63:0] r_seed_word;
    logic [63:0] r_p0;
    logic [31:0] r_p1;
    logic [31:0] r_p2;
    logic [63:0] r_out_word;
    logic        r_out_valid;

    logic [63:0] seed_x;
    logic [31:0] mul_lo;
    logic [31:0] mul_hi;
    logic [31:0] cross_sum;
    logic [63:0] seed_sum;
    logic [63:0] twist_y;
    logic [63:0] twist_word;
    logic [63:0] wdata;

    // seeding recurrence operand and its low 64-bit product terms
    assign seed_x    = r_seed_word ^ (r_seed_word >> 62);
    assign mul_lo    = C_SEED_MULT[31:0];
    assign mul_hi    = C_SEED_MULT[63:32];
    assign cross_sum = r_p1 + r_p2;
    assign seed_sum  = r_p0 + {cross_sum, 32'd0} + {{(64 - C_IDX_W){1'b0}}, i_cmd.waddr};

    // twist of one word: upper bits of current, lower bits of next, far word
    assign twist_y    = (r_cur & C_UPPER_MASK) | (r_rd_a & C_LOWER_MASK);
    assign twist_word = r_rd_b ^ (twist_y >> 1) ^ (twist_y[0] ? C_TWIST_MATRIX : 64'd0);

    // select write data
    always_comb begin
        case (i_cmd.wsel)
            WSEL_SEED_IN:   wdata = i_cmd.seed_default ? C_DEFAULT_SEED : i_seed_value;
            WSEL_SEED_CALC: wdata = seed_sum;
            WSEL_TWIST:     wdata = twist_word;
            default:        wdata = twist_word;
        endcase
    end

    // state store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[i_cmd.waddr] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_a <= r_mem[i_cmd.addr_a];
            r_rd_b <= r_mem[i_cmd.addr_b];
        end
    end

    // seeding chain and twist current word
    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_init) begin
            r_seed_word <= i_cmd.seed_default ? C_DEFAULT_SEED : i_seed_value;
        end else if (i_cmd.sum_en) begin
            r_seed_word <= seed_sum;
        end
        if (i_cmd.mul_en) begin
            r_p0 <= {32'd0, seed_x[31:0]} * {32'd0, mul_lo};
            r_p1 <= seed_x[63:32] * mul_lo;
            r_p2 <= seed_x[31:0] * mul_hi;
        end
        if (i_cmd.cur_load) begin
            r_cur <= r_rd_a;
        end
        if (i_cmd.out_load) begin
            r_out_word <= f_temper(r_rd_a);
        end
    end

    // output valid: set on load, drop once the transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || !i_stall;
    assign o_valid           = r_out_valid;
    assign o_random_word     = r_out_word;

endmodule

// ===== design/mt64_ctrl.sv =====
// ----------------------------------------------------------------------------
// mt64_ctrl
// Sequencer for seeding, twisting and drawing; owns the word position.
// ----------------------------------------------------------------------------
module mt64_ctrl
    import mt64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    output t_dp_cmd     o_cmd,
    input  t_dp_status  i_status
);

    t_state             r_state, n_state;
    logic [C_IDX_W-1:0] r_k, n_k;
    logic [C_POS_W-1:0] r_pos, n_pos;
    logic               r_pend, n_pend;

    logic               accept;
    logic [C_IDX_W-1:0] next_idx;
    logic [C_IDX_W-1:0] far_idx;

    assign accept   = i_valid && (r_state == ST_IDLE);
    assign o_stall  = (r_state != ST_IDLE);
    assign next_idx = (r_k == C_LAST_IDX) ? '0 : r_k + 1'b1;
    assign far_idx  = (r_k < C_SHIFT_IDX) ? r_k + C_SHIFT_IDX : r_k - C_SHIFT_IDX;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_pos   <= C_POS_UNSEEDED;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_pos   <= n_pos;
            r_pend  <= n_pend;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_pos   = r_pos;
        n_pend  = r_pend;

        o_cmd.mem_we       = 1'b0;
        o_cmd.waddr        = r_k;
        o_cmd.wsel         = WSEL_TWIST;
        o_cmd.rd_en        = 1'b0;
        o_cmd.addr_a       = next_idx;
        o_cmd.addr_b       = far_idx;
        o_cmd.seed_init    = 1'b0;
        o_cmd.seed_default = 1'b0;
        o_cmd.mul_en       = 1'b0;
        o_cmd.sum_en       = 1'b0;
        o_cmd.cur_load     = 1'b0;
        o_cmd.out_load     = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_action == C_ACT_RESEED || r_pos == C_POS_UNSEEDED) begin
                        // load word 0 from the seed and start the recurrence
                        o_cmd.seed_init    = 1'b1;
                        o_cmd.seed_default = (i_action != C_ACT_RESEED);
                        o_cmd.mem_we       = 1'b1;
                        o_cmd.waddr        = '0;
                        o_cmd.wsel         = WSEL_SEED_IN;
                        n_k                = C_IDX_W'(1);
                        n_pend             = (i_action != C_ACT_RESEED);
                        n_state            = ST_SEED_MUL;
                    end else if (r_pos == C_POS_TWIST) begin
                        n_pend  = 1'b1;
                        n_state = ST_TW_PRIME;
                    end else begin
                        // fetch the next word to temper
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.addr_a = r_pos[C_IDX_W-1:0];
                        n_pos        = r_pos + 1'b1;
                        n_state      = ST_DRAW_OUT;
                    end
                end
            end

            ST_SEED_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = ST_SEED_SUM;
            end

            ST_SEED_SUM: begin
                o_cmd.sum_en = 1'b1;
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = WSEL_SEED_CALC;
                if (r_k == C_LAST_IDX) begin
                    n_pos   = C_POS_TWIST;
                    n_state = r_pend ? ST_TW_PRIME : ST_IDLE;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_SEED_MUL;
                end
            end

            ST_TW_PRIME: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.addr_a = '0;
                n_k          = '0;
                n_state      = ST_TW_LOAD;
            end

            ST_TW_LOAD: begin
                o_cmd.cur_load = 1'b1;
                n_state        = ST_TW_READ;
            end

            ST_TW_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_TW_WRITE;
            end

            ST_TW_WRITE: begin
                o_cmd.mem_we   = 1'b1;
                o_cmd.wsel     = WSEL_TWIST;
                o_cmd.cur_load = 1'b1;
                if (r_k == C_LAST_IDX) begin
                    // twist done: fetch word 0 for the pending draw
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.addr_a = '0;
                    n_pos        = C_POS_W'(1);
                    n_pend       = 1'b0;
                    n_state      = ST_DRAW_OUT;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_TW_READ;
                end
            end

            ST_DRAW_OUT: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/mt19937_64_generator_top.sv =====
// ----------------------------------------------------------------------------
// A draw's word is read, then tempered into the output register once that register is free;
// the input stalls meanwhile. Every 312th draw first twists the state, two reads a word.
// A reseed keeps the input stalled while it seeds each word in a multiply and a sum state.
// A draw before any reseed seeds with 5489, twists, then draws.
// Reset clears control only; the state store is undefined until seeded.
// ----------------------------------------------------------------------------
// mt19937_64_generator_top
// 64-bit Mersenne Twister: reseed and draw transactions in, tempered words out.
// ----------------------------------------------------------------------------
module mt19937_64_generator_top
    import mt64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [63:0] i_seed_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_random_word
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencer
    mt64_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_action (i_action),
        .o_cmd    (cmd),
        .i_status (status)
    );

    // state store and arithmetic
    mt64_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_seed_value  (i_seed_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_random_word (o_random_word)
    );

endmodule
